>>> src/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Types, constants and the per-nibble decode step for the subpicture run
// decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int CfgWidthBits  = 12;
    localparam int LineBits      = 11;
    localparam int PartialBits   = 12;

    localparam logic [0:0] REG_BITMAP_WIDTH  = 1'b0;
    localparam logic [0:0] REG_BITMAP_HEIGHT = 1'b1;

    localparam logic [11:0] WIDTH_RESET  = 12'd720;
    localparam logic [11:0] HEIGHT_RESET = 12'd576;

    localparam logic [15:0] CODE_MIN_ONE   = 16'h0004;
    localparam logic [15:0] CODE_MIN_TWO   = 16'h0010;
    localparam logic [15:0] CODE_MIN_THREE = 16'h0040;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_field;
        logic       field_parity;
    } srd_in_t;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] start_column;
        logic [11:0] run_length;
        logic [1:0]  colour_index;
        logic        last;
    } srd_out_t;

    typedef struct packed {
        logic [PartialBits-1:0]  partial_code;
        logic [1:0]              code_nibbles;
        logic [CfgWidthBits-1:0] column;
        logic [LineBits-1:0]     field_line;
        logic                    parity_bit;
    } srd_state_t;

    typedef struct packed {
        srd_state_t state;
        logic       emit;
        logic       ended;
        srd_out_t   run;
    } srd_step_t;

    function automatic srd_step_t srd_feed(
        input srd_state_t        st,
        input logic [3:0]        nib,
        input logic [CfgWidthBits-1:0] width
    );
        srd_step_t               res;
        logic [15:0]             code;
        logic [2:0]              n;
        logic                    done;
        logic [13:0]             run_raw;
        logic [CfgWidthBits-1:0] rem;
        logic [CfgWidthBits-1:0] run;
        logic [CfgWidthBits-1:0] col_next;

        res       = '0;
        res.state = st;
        code      = {st.partial_code, nib};
        n         = {1'b0, st.code_nibbles} + 3'd1;
        unique case (n)
            3'd1:    done = (code >= CODE_MIN_ONE);
            3'd2:    done = (code >= CODE_MIN_TWO);
            3'd3:    done = (code >= CODE_MIN_THREE);
            default: done = 1'b1;
        endcase

        run_raw  = code[15:2];
        rem      = (st.column < width) ? (width - st.column) : '0;
        run      = ((run_raw == '0) || (run_raw > {2'b00, rem})) ? rem : run_raw[11:0];
        col_next = st.column + run;

        if (!done)
        begin
            res.state.partial_code = code[PartialBits-1:0];
            res.state.code_nibbles = n[1:0];
        end
        else
        begin
            res.state.partial_code  = '0;
            res.state.code_nibbles  = '0;
            res.emit                = (run != '0);
            res.run.row             = {st.field_line, st.parity_bit};
            res.run.start_column    = st.column;
            res.run.run_length      = run;
            res.run.colour_index    = ~code[1:0];
            res.run.last            = 1'b0;
            if (col_next >= width)
            begin
                res.state.field_line = st.field_line + 11'd1;
                res.state.column     = '0;
                res.ended            = 1'b1;
            end
            else
            begin
                res.state.column = col_next;
            end
        end
        return res;
    endfunction

endpackage

>>> src/subpicture_rle_run_decoder_core.sv
// ----------------------------------------------------------------------------
// subpicture_rle_run_decoder_core
// Decodes the run-length coded bitmap of one subpicture field into runs.
// ----------------------------------------------------------------------------
// A byte is accepted while the hold register is empty or the result buffer
// drains its last run. It is registered, decoded (both nibbles) into a
// two-entry result buffer once that buffer is free, and its runs leave the
// buffer one per cycle on the output channel while out_ready is high.
// Widths and heights are for the user to write through the APB port only
// while idle; the block itself does not enforce it.
module subpicture_rle_run_decoder_core
    import srd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  srd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output srd_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    srd_state_t  state_reg;
    srd_state_t  state_next;
    logic        hold_valid_reg;
    srd_in_t     hold_reg;
    srd_out_t    res_reg [2];
    srd_out_t    res_next [2];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        idx_reg;

    logic        drain_done;
    logic        buf_free;
    logic        advance;
    logic        cfg_write;
    srd_state_t  st_start;
    srd_step_t   step_a;
    srd_step_t   step_b;
    logic        active;
    logic        do_b;
    logic [10:0] half_height;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_BITMAP_HEIGHT) ? {20'd0, height_reg}
                                                       : {20'd0, width_reg};

    assign out_valid  = (count_reg != 2'd0);
    assign out_data   = res_reg[idx_reg];
    assign drain_done = out_valid && out_ready && ({1'b0, idx_reg} == (count_reg - 2'd1));
    assign buf_free   = !out_valid || drain_done;
    assign advance    = hold_valid_reg && buf_free;
    assign in_ready   = !hold_valid_reg || buf_free;
    assign half_height = height_reg[11:1];

    always_comb
    begin
        st_start = state_reg;
        if (hold_reg.new_field)
        begin
            st_start            = '0;
            st_start.parity_bit = hold_reg.field_parity;
        end
        active = (st_start.field_line < half_height);
        step_a = srd_feed(st_start, hold_reg.data_byte[7:4], width_reg);
        do_b   = !step_a.ended && (step_a.state.field_line < half_height);
        step_b = srd_feed(step_a.state, hold_reg.data_byte[3:0], width_reg);

        state_next  = st_start;
        count_next  = 2'd0;
        res_next[0] = step_a.run;
        res_next[1] = step_b.run;
        if (active)
        begin
            state_next = do_b ? step_b.state : step_a.state;
            if (step_a.emit && do_b && step_b.emit)
            begin
                count_next       = 2'd2;
                res_next[1].last = 1'b1;
            end
            else if (step_a.emit)
            begin
                count_next       = 2'd1;
                res_next[0].last = 1'b1;
            end
            else if (do_b && step_b.emit)
            begin
                count_next       = 2'd1;
                res_next[0]      = step_b.run;
                res_next[0].last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            state_reg      <= '0;
            hold_valid_reg <= 1'b0;
            count_reg      <= 2'd0;
            idx_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == REG_BITMAP_HEIGHT)
                begin
                    height_reg <= pwdata[11:0];
                end
                else
                begin
                    width_reg <= pwdata[11:0];
                end
            end

            if (in_valid && in_ready)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
                idx_reg   <= 1'b0;
            end
            else if (drain_done)
            begin
                count_reg <= 2'd0;
                idx_reg   <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                idx_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_reg <= in_data;
        end
        if (advance)
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
        end
    end

endmodule

>>> bench/srd_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_run_checker
// Watches the byte, run and register ports of the subpicture run decoder,
// predicts the runs of each accepted request from its own copy of the
// decoder state and compares them in order with the runs that come out.
// ----------------------------------------------------------------------------
module srd_run_checker
    import srd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  srd_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  srd_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatch_count,
    output int          pending_runs
);

    logic [11:0] width_cfg;
    logic [11:0] height_cfg;
    logic [15:0] code_acc;
    logic [1:0]  nib_count;
    logic [11:0] col_pos;
    logic [10:0] line_pos;
    logic        parity_pos;
    srd_out_t    expected_runs [$];
    int          errors;

    task automatic decode_nibble(
        input  logic [3:0] nib,
        output bit         line_done,
        output bit         emitted,
        output srd_out_t   run
    );
        logic [15:0] code;
        logic [2:0]  count;
        bit          complete;
        logic [13:0] span;
        logic [11:0] room;

        code      = {code_acc[11:0], nib};
        count     = {1'b0, nib_count} + 3'd1;
        line_done = 1'b0;
        emitted   = 1'b0;
        run       = '0;
        case (count)
            3'd1:    complete = (code >= CODE_MIN_ONE);
            3'd2:    complete = (code >= CODE_MIN_TWO);
            3'd3:    complete = (code >= CODE_MIN_THREE);
            default: complete = 1'b1;
        endcase
        if (!complete)
        begin
            code_acc  = code;
            nib_count = count[1:0];
        end
        else
        begin
            code_acc  = '0;
            nib_count = '0;
            span      = code[15:2];
            room      = (col_pos < width_cfg) ? (width_cfg - col_pos) : 12'd0;
            if ((span == 14'd0) || (span > {2'b00, room}))
            begin
                span = {2'b00, room};
            end
            if (span != 14'd0)
            begin
                emitted          = 1'b1;
                run.row          = {line_pos, parity_pos};
                run.start_column = col_pos;
                run.run_length   = span[11:0];
                run.colour_index = 2'd3 - code[1:0];
                run.last         = 1'b0;
            end
            col_pos = col_pos + span[11:0];
            if (col_pos >= width_cfg)
            begin
                line_pos  = line_pos + 11'd1;
                col_pos   = '0;
                line_done = 1'b1;
            end
        end
    endtask

    task automatic decode_rle_byte(input srd_in_t req);
        srd_out_t runs [2];
        srd_out_t run;
        int       found;
        bit       line_done;
        bit       emitted;

        found = 0;
        if (req.new_field)
        begin
            code_acc   = '0;
            nib_count  = '0;
            col_pos    = '0;
            line_pos   = '0;
            parity_pos = req.field_parity;
        end
        if ({1'b0, line_pos} < (height_cfg >> 1))
        begin
            decode_nibble(req.data_byte[7:4], line_done, emitted, run);
            if (emitted)
            begin
                runs[found] = run;
                found++;
            end
            if (!line_done)
            begin
                decode_nibble(req.data_byte[3:0], line_done, emitted, run);
                if (emitted)
                begin
                    runs[found] = run;
                    found++;
                end
            end
        end
        if (found > 0)
        begin
            runs[found - 1].last = 1'b1;
        end
        for (int i = 0; i < found; i++)
        begin
            expected_runs.push_back(runs[i]);
        end
    endtask

    task automatic check_run(input srd_out_t got);
        srd_out_t want;

        if (expected_runs.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("ERROR: unexpected run row=%0d col=%0d len=%0d colour=%0d last=%0d",
                         got.row, got.start_column, got.run_length, got.colour_index,
                         got.last);
            end
        end
        else
        begin
            want = expected_runs.pop_front();
            if ((got.row !== want.row) || (got.start_column !== want.start_column) ||
                (got.run_length !== want.run_length) ||
                (got.colour_index !== want.colour_index) || (got.last !== want.last))
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: run mismatch at %0t", $realtime);
                    $display("  expected row=%0d col=%0d len=%0d colour=%0d last=%0d",
                             want.row, want.start_column, want.run_length,
                             want.colour_index, want.last);
                    $display("  actual   row=%0d col=%0d len=%0d colour=%0d last=%0d",
                             got.row, got.start_column, got.run_length,
                             got.colour_index, got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg  = WIDTH_RESET;
            height_cfg = HEIGHT_RESET;
            code_acc   = '0;
            nib_count  = '0;
            col_pos    = '0;
            line_pos   = '0;
            parity_pos = 1'b0;
            errors     = 0;
            expected_runs.delete();
            mismatch_count <= 0;
            pending_runs   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_run(out_data);
            end
            if (in_valid && in_ready)
            begin
                decode_rle_byte(in_data);
            end
            if (psel && penable && pwrite && pready && (paddr[1:0] == 2'b00))
            begin
                if (paddr[2] == REG_BITMAP_WIDTH)
                begin
                    width_cfg = pwdata[11:0];
                end
                else if (paddr[2] == REG_BITMAP_HEIGHT)
                begin
                    height_cfg = pwdata[11:0];
                end
            end
            mismatch_count <= errors;
            pending_runs   <= expected_runs.size();
        end
    end

endmodule

>>> bench/subpicture_rle_run_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpicture_rle_run_decoder_core_test
// Drives RLE byte requests and register writes into the run decoder, with
// bursty requests and a stalling run receiver, across several line widths
// and field heights. The checker beside the block predicts every run.
// ----------------------------------------------------------------------------
module subpicture_rle_run_decoder_core_test;
    import srd_pkg::*;

    localparam int ItemCount  = 1500;
    localparam int PhaseCount = 14;
    localparam int CycleLimit = 400000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    srd_in_t     in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    srd_out_t    out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pending_runs;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          mode_left   = 0;
    stall_mode_t stall_mode  = READY_ALWAYS;

    subpicture_rle_run_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    srd_run_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_runs   (pending_runs)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 300);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   out_ready <= ($urandom_range(0, 4) == 0);
            default:        out_ready <= ((cycle_count % 8) < 5);
        endcase
    end

    task automatic send_request(input srd_in_t req);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_rle_byte(input bit nf, input bit par, input logic [7:0] value);
        srd_in_t req;

        req.data_byte    = value;
        req.new_field    = nf;
        req.field_parity = par;
        send_request(req);
    endtask

    task automatic drain_runs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_runs != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [11:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {20'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_bitmap(input logic [11:0] width, input logic [11:0] height);
        write_register(REG_BITMAP_WIDTH, width);
        write_register(REG_BITMAP_HEIGHT, height);
    endtask

    function automatic logic [7:0] random_rle_byte();
        logic [7:0] value;

        value = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1:    value[7:4] = 4'h0;
            2:       value = 8'h00;
            3:       value[7:6] = 2'b00;
            default: ;
        endcase
        return value;
    endfunction

    task automatic send_random_bytes(input int count, input bit open_field);
        srd_in_t req;
        int      field_left;

        field_left = 0;
        for (int i = 0; i < count; i++)
        begin
            req.data_byte    = random_rle_byte();
            req.field_parity = 1'($urandom_range(0, 1));
            req.new_field    = 1'b0;
            if (field_left == 0)
            begin
                req.new_field = (i != 0) || open_field;
                field_left    = $urandom_range(4, 80);
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                req.new_field = 1'b1;
            end
            field_left--;
            send_request(req);
        end
    endtask

    initial
    begin
        logic [11:0] width;
        logic [11:0] height;
        int          count;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: codes of every length, a zero run and a line end on
        // the high nibble that drops the low one.
        send_rle_byte(1'b1, 1'b1, 8'h5F);
        send_rle_byte(1'b0, 1'b0, 8'h12);
        send_rle_byte(1'b0, 1'b0, 8'h05);
        send_rle_byte(1'b0, 1'b1, 8'h7A);
        send_rle_byte(1'b0, 1'b0, 8'h00);
        send_rle_byte(1'b0, 1'b0, 8'h3F);
        send_rle_byte(1'b0, 1'b0, 8'h03);
        send_rle_byte(1'b0, 1'b0, 8'hFF);
        send_rle_byte(1'b0, 1'b0, 8'h40);
        send_rle_byte(1'b0, 1'b0, 8'h00);
        send_rle_byte(1'b0, 1'b0, 8'h2F);
        send_rle_byte(1'b0, 1'b0, 8'h01);
        send_rle_byte(1'b1, 1'b0, 8'hC4);
        send_rle_byte(1'b0, 1'b0, 8'h00);
        send_rle_byte(1'b0, 1'b0, 8'h03);
        drain_runs();

        // Narrow, short field: overlong runs, a finished field and ignored bytes.
        set_bitmap(12'd5, 12'd6);
        send_rle_byte(1'b1, 1'b0, 8'hF4);
        send_rle_byte(1'b0, 1'b0, 8'h0F);
        send_rle_byte(1'b0, 1'b0, 8'hF0);
        send_rle_byte(1'b0, 1'b0, 8'h80);
        send_rle_byte(1'b0, 1'b0, 8'h00);
        send_rle_byte(1'b0, 1'b0, 8'h08);
        send_rle_byte(1'b0, 1'b1, 8'hFF);
        send_rle_byte(1'b1, 1'b1, 8'h55);
        drain_runs();

        // Shrinking the line below the current column leaves no room.
        set_bitmap(12'd1, 12'd4095);
        send_rle_byte(1'b0, 1'b0, 8'h4F);
        send_rle_byte(1'b0, 1'b1, 8'h77);
        drain_runs();

        for (int p = 0; p < PhaseCount; p++)
        begin
            count = ItemCount / PhaseCount;
            case (p)
                0:
                begin
                    width  = 12'd4095;
                    height = 12'd4095;
                end
                1:
                begin
                    width  = 12'd2;
                    height = 12'd0;
                    count  = 20;
                end
                2:
                begin
                    width  = 12'd3;
                    height = 12'd1;
                    count  = 20;
                end
                3:
                begin
                    width  = 12'd3;
                    height = 12'd4095;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: width = 12'($urandom_range(1, 16));
                        5, 6, 7:       width = 12'($urandom_range(17, 200));
                        default:       width = 12'($urandom_range(201, 4095));
                    endcase
                    height = ($urandom_range(0, 9) == 0) ? 12'd4095
                                                         : 12'($urandom_range(2, 64));
                end
            endcase
            set_bitmap(width, height);
            send_random_bytes(count, 1'($urandom_range(0, 1)));
            drain_runs();
        end

        if (mismatch_count == 0 && pending_runs == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
